@@ rtl/jva_pkg.sv @@
// jva_pkg: shared types and constants for the joystick vector angle pipeline.
// Holds the arctangent table, angle constants and the stage control struct.
// No dependencies.
`timescale 1ns / 1ps

package jva_pkg;

  // Register indexes on the configuration channel
  typedef enum logic [0:0] {
    REG_CENTER_X = 1'b0,
    REG_CENTER_Y = 1'b1
  } reg_index_t;

  localparam int          CENTER_MIN_W  = 12;     // holds the reset center value
  localparam int          CENTER_RESET  = 2048;
  localparam int          SCALE_SHIFT   = 16;     // offsets scaled by 2^16
  localparam int          GUARD_BITS    = 20;     // scale plus CORDIC growth plus sign
  localparam int          Z_W           = 32;     // degrees * 2^22, signed
  localparam int          ANGLE_W       = 15;
  localparam int          OUT_TDATA_W   = 16;
  localparam int          TABLE_LEN     = 24;

  localparam logic signed [Z_W-1:0] ANG_HALF     = 32'sd754974720;   // 180 deg
  localparam logic signed [Z_W-1:0] ANG_ROUND    = 32'sd32768;       // half of 1/64 deg
  localparam logic signed [Z_W-1:0] ANG_FULL_RND = 32'sd1509982208;  // 360 deg + round
  localparam logic [ANGLE_W-1:0]    ANGLE_WRAP   = 15'd23040;        // 360 deg in q6

  // atan(2^-i) in degrees * 2^22, rounded to nearest
  localparam logic signed [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
    32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
    32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
    32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
    32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
    32'sd229,       32'sd115,       32'sd57,       32'sd29
  };

  // Control that travels with each pipeline slot
  typedef struct packed {
    logic valid;
    logic zero;   // sample equals the center: result forced to 0
  } pipe_ctl_t;

endpackage

@@ rtl/jva_prerot.sv @@
// jva_prerot: first pipeline stage. Forms center offsets, folds the left half
// plane by 180 degrees and scales to the CORDIC word. Depends on jva_pkg.
`timescale 1ns / 1ps

module jva_prerot #(
  parameter int SAMPLE_BITS = 12,
  parameter int CENTER_W    = 12,
  parameter int W           = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [CENTER_W-1:0]           center_x,
  input  logic [CENTER_W-1:0]           center_y,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        raw_x,
  input  logic [SAMPLE_BITS-1:0]        raw_y,
  output jva_pkg::pipe_ctl_t            out_ctl,
  input  logic                          out_ready,
  output logic signed [W-1:0]           x_out,
  output logic signed [W-1:0]           y_out,
  output logic signed [jva_pkg::Z_W-1:0] z_out
);

  localparam int DW = CENTER_W + 1;

  logic signed [DW-1:0]           dx;
  logic signed [DW-1:0]           dy;
  logic signed [W-1:0]            dxw;
  logic signed [W-1:0]            dyw;
  logic                           left;
  logic signed [W-1:0]            x_next;
  logic signed [W-1:0]            y_next;
  logic signed [jva_pkg::Z_W-1:0] z_next;

  always_comb begin
    dx     = $signed(DW'(raw_x)) - $signed(DW'(center_x));
    dy     = $signed(DW'(center_y)) - $signed(DW'(raw_y));
    dxw    = W'(dx);
    dyw    = W'(dy);
    left   = dx[DW-1];
    x_next = (left ? -dxw : dxw) <<< jva_pkg::SCALE_SHIFT;
    y_next = (left ? -dyw : dyw) <<< jva_pkg::SCALE_SHIFT;
    z_next = left ? jva_pkg::ANG_HALF : '0;
  end

  assign in_ready = !out_ctl.valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else if (in_ready) begin
      out_ctl.valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_ctl.zero <= (dx == '0) && (dy == '0);
      x_out        <= x_next;
      y_out        <= y_next;
      z_out        <= z_next;
    end
  end

endmodule

@@ rtl/jva_cordic_stage.sv @@
// jva_cordic_stage: one registered CORDIC vectoring micro-rotation.
// Stage index selects the shift and the arctangent constant. Depends on jva_pkg.
`timescale 1ns / 1ps

module jva_cordic_stage #(
  parameter int STAGE = 0,
  parameter int W     = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  jva_pkg::pipe_ctl_t             in_ctl,
  output logic                           in_ready,
  input  logic signed [W-1:0]            x_in,
  input  logic signed [W-1:0]            y_in,
  input  logic signed [jva_pkg::Z_W-1:0] z_in,
  output jva_pkg::pipe_ctl_t             out_ctl,
  input  logic                           out_ready,
  output logic signed [W-1:0]            x_out,
  output logic signed [W-1:0]            y_out,
  output logic signed [jva_pkg::Z_W-1:0] z_out
);

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;
  logic                y_pos;

  // arithmetic shift rounds toward minus infinity
  assign xs    = x_in >>> STAGE;
  assign ys    = y_in >>> STAGE;
  assign y_pos = !y_in[W-1] && (y_in != '0);

  assign in_ready = !out_ctl.valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else if (in_ready) begin
      out_ctl.valid <= in_ctl.valid;
    end
    if (in_ready && in_ctl.valid) begin
      out_ctl.zero <= in_ctl.zero;
      if (y_pos) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + jva_pkg::ATAN_TAB[STAGE];
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - jva_pkg::ATAN_TAB[STAGE];
      end
    end
  end

endmodule

@@ rtl/jva_round.sv @@
// jva_round: last stage. Folds negative angles into [0, 360), rounds to
// 1/64 degree, wraps a full circle to 0 and holds the result. Depends on jva_pkg.
`timescale 1ns / 1ps

module jva_round (
  input  logic                              clk,
  input  logic                              rst,
  input  jva_pkg::pipe_ctl_t                in_ctl,
  output logic                              in_ready,
  input  logic signed [jva_pkg::Z_W-1:0]    z_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [jva_pkg::ANGLE_W-1:0]       angle
);

  logic signed [jva_pkg::Z_W-1:0] z_rnd;
  logic [jva_pkg::ANGLE_W-1:0]    q;
  logic [jva_pkg::ANGLE_W-1:0]    angle_next;

  always_comb begin
    // one add both lifts a negative angle by 360 degrees and adds the rounding half
    z_rnd = z_in + (z_in[jva_pkg::Z_W-1] ? jva_pkg::ANG_FULL_RND : jva_pkg::ANG_ROUND);
    q     = z_rnd[jva_pkg::SCALE_SHIFT +: jva_pkg::ANGLE_W];
    if (in_ctl.zero) begin
      angle_next = '0;
    end else if (q >= jva_pkg::ANGLE_WRAP) begin
      angle_next = q - jva_pkg::ANGLE_WRAP;
    end else begin
      angle_next = q;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ctl.valid) begin
      angle <= angle_next;
    end
  end

endmodule

@@ rtl/joystick_vector_angle.sv @@
// joystick_vector_angle: top level of the pipelined CORDIC joystick direction unit.
// Depends on jva_pkg, jva_prerot, jva_cordic_stage and jva_round.
`timescale 1ns / 1ps

// Usage
//   s_* stream: one raw joystick sample per transaction, raw_x in the low
//   SAMPLE_BITS of s_tdata and raw_y right above it.
//   m_* stream: one angle per sample, in 1/64 degree counter-clockwise from +x
//   (0 .. 23039), in m_tdata[14:0]. A sample at the center gives 0.
//   cfg_* channel: cfg_index 0 writes center_x, 1 writes center_y; always ready.
//   Write the centers only while no sample is in flight.
// Timing
//   CORDIC_STAGES + 2 register slots: one offset/fold stage, one per CORDIC
//   rotation, one rounding stage.
//   Throughput is one sample per clock while m_tready is high; every stage is
//   a register slot with its own valid bit.
// Reset
//   rst (synchronous) empties the pipeline and sets both centers to 2048.
// Back-pressure
//   When m_tready is low, the held result stays in the output register and the
//   stages behind it keep filling empty slots, so s_tready stays high until all
//   slots are full. Nothing is dropped or repeated.
module joystick_vector_angle #(
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // s_tdata: raw_x [SAMPLE_BITS-1:0], raw_y [2*SAMPLE_BITS-1:SAMPLE_BITS], zero pad
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,
  // m_tdata: angle_q6 [14:0], zero pad [15]
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  output logic [jva_pkg::OUT_TDATA_W-1:0]            m_tdata,
  // configuration write channel
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [0:0]                                 cfg_index,
  input  logic [SAMPLE_BITS-1:0]                     cfg_data
);

  // centers need 12 bits to hold the reset value even for narrow samples
  localparam int CENTER_W = (SAMPLE_BITS > jva_pkg::CENTER_MIN_W) ? SAMPLE_BITS
                                                                  : jva_pkg::CENTER_MIN_W;
  localparam int W        = CENTER_W + jva_pkg::GUARD_BITS;
  localparam int N        = CORDIC_STAGES;

  logic [CENTER_W-1:0]            center_x;
  logic [CENTER_W-1:0]            center_y;
  logic [jva_pkg::ANGLE_W-1:0]    angle_q6;

  jva_pkg::pipe_ctl_t             ctl [0:N];
  logic                           rdy [0:N];
  logic signed [W-1:0]            xs  [0:N];
  logic signed [W-1:0]            ys  [0:N];
  logic signed [jva_pkg::Z_W-1:0] zs  [0:N];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= CENTER_W'(jva_pkg::CENTER_RESET);
      center_y <= CENTER_W'(jva_pkg::CENTER_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (jva_pkg::reg_index_t'(cfg_index))
        jva_pkg::REG_CENTER_X: center_x <= CENTER_W'(cfg_data);
        jva_pkg::REG_CENTER_Y: center_y <= CENTER_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Offsets and half-plane fold
  jva_prerot #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CENTER_W    (CENTER_W),
    .W           (W)
  ) u_prerot (
    .clk       (clk),
    .rst       (rst),
    .center_x  (center_x),
    .center_y  (center_y),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .raw_x     (s_tdata[SAMPLE_BITS-1:0]),
    .raw_y     (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .out_ctl   (ctl[0]),
    .out_ready (rdy[0]),
    .x_out     (xs[0]),
    .y_out     (ys[0]),
    .z_out     (zs[0])
  );

  // One register stage per micro-rotation
  for (genvar g = 0; g < N; g++) begin : g_stage
    jva_cordic_stage #(
      .STAGE (g),
      .W     (W)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_ctl    (ctl[g]),
      .in_ready  (rdy[g]),
      .x_in      (xs[g]),
      .y_in      (ys[g]),
      .z_in      (zs[g]),
      .out_ctl   (ctl[g+1]),
      .out_ready (rdy[g+1]),
      .x_out     (xs[g+1]),
      .y_out     (ys[g+1]),
      .z_out     (zs[g+1])
    );
  end

  // Wrap, round and output register
  jva_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (ctl[N]),
    .in_ready  (rdy[N]),
    .z_in      (zs[N]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .angle     (angle_q6)
  );

  assign m_tdata = {{(jva_pkg::OUT_TDATA_W - jva_pkg::ANGLE_W){1'b0}}, angle_q6};

  // Assertions

  // result always within one turn
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (angle_q6 < jva_pkg::ANGLE_WRAP))
    else $error("angle out of range");

  // a taken output frees a slot all the way back to the input
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking testbench for joystick_vector_angle (CORDIC stick direction).
// Checks every angle against a bit-true predictor while sweeping the centers.
// Depends on jva_pkg and the joystick_vector_angle RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int SAMPLE_W    = 12;
  localparam int STAGE_CNT   = 16;
  localparam int PIPE_DEPTH  = STAGE_CNT + 2;    // offset/fold + stages + rounding
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 100;              // result count that starts the long stall
  localparam int HOLD_CYCLES = 150;
  localparam int SMAX        = (1 << SAMPLE_W) - 1;

  // Angle accumulator scale: degrees * 2^22
  localparam longint DEG_UNIT  = 64'sd4194304;
  localparam longint TURN_HALF = 180 * DEG_UNIT;
  localparam longint TURN_FULL = 360 * DEG_UNIT;
  localparam longint Q6_WRAP   = 23040;          // 360 degrees in 1/64 degree

  // atan(2^-i) in degrees * 2^22, rounded to nearest
  localparam longint ATAN_DEG22 [24] = '{
    188743680, 111421900, 58872272, 29884485,
    15000234,  7507429,   3754631,  1877430,
    938729,    469366,    234683,   117342,
    58671,     29335,     14668,    7334,
    3667,      1833,      917,      458,
    229,       115,       57,       29
  };

  // One stick sample; raw_x lands in the low bits of s_tdata
  typedef struct packed {
    logic [SAMPLE_W-1:0] raw_y;
    logic [SAMPLE_W-1:0] raw_x;
  } sample_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  sample_t     s_tdata   = '0;      // raw_x [11:0], raw_y [23:12]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;             // angle_q6 [14:0], pad [15]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  jva_pkg::reg_index_t cfg_index = jva_pkg::REG_CENTER_X;
  logic [SAMPLE_W-1:0] cfg_data = '0;

  // Testbench copy of the center registers, updated on each config transaction
  int ctr_x = 2048;
  int ctr_y = 2048;

  sample_t      sample_q [$];       // samples waiting to be offered
  logic [14:0]  angle_q  [$];       // predicted angles, oldest first

  bit  idle_en = 1'b1;              // random gaps on both sides
  bit  failed  = 1'b0;
  int  src_idle;
  int  sink_idle;
  int  hold_left;
  int  n_angles;
  int  cycle_cnt;

  joystick_vector_angle #(
    .CORDIC_STAGES (STAGE_CNT),
    .SAMPLE_BITS   (SAMPLE_W)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Predicted direction: offsets from the centers (y flipped so up is positive),
  // fold the left half plane by 180 deg, then vectoring rotations with floor shifts.
  function automatic logic [14:0] predict_angle(sample_t s);
    longint px, py, dx, dy, x, y, z, xs, ys, q;
    px = s.raw_x;
    py = s.raw_y;
    dx = px - ctr_x;
    dy = ctr_y - py;
    if (dx == 0 && dy == 0) return '0;
    if (dx < 0) begin
      x = -dx;
      y = -dy;
      z = TURN_HALF;
    end else begin
      x = dx;
      y = dy;
      z = 0;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < STAGE_CNT && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_DEG22[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_DEG22[i];
      end
    end
    while (z < 0) z = z + TURN_FULL;
    q = (z + 32768) >>> 16;
    while (q >= Q6_WRAP) q = q - Q6_WRAP;
    return q[14:0];
  endfunction

  // Random sample: mostly uniform, with a share near the rest point, on an
  // axis through the center, and on the corners of the range.
  function automatic sample_t pick_sample();
    sample_t s;
    int kind, vx, vy;
    kind = $urandom_range(0, 15);
    vx = $urandom_range(0, SMAX);
    vy = $urandom_range(0, SMAX);
    if (kind < 3) begin
      vx = ctr_x + int'($urandom_range(0, 8)) - 4;
      vy = ctr_y + int'($urandom_range(0, 8)) - 4;
    end else if (kind == 3) begin
      vx = ctr_x;
    end else if (kind == 4) begin
      vy = ctr_y;
    end else if (kind == 5) begin
      vx = $urandom_range(0, 1) ? SMAX : 0;
      vy = $urandom_range(0, 1) ? SMAX : 0;
    end
    if (vx < 0) vx = 0;
    if (vx > SMAX) vx = SMAX;
    if (vy < 0) vy = 0;
    if (vy > SMAX) vy = SMAX;
    s.raw_x = vx[SAMPLE_W-1:0];
    s.raw_y = vy[SAMPLE_W-1:0];
    return s;
  endfunction

  // Sender: offers queued samples, predicts at each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_idle = 0;
    end else begin
      if (s_tvalid && s_tready)
        angle_q.push_back(predict_angle(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (src_idle > 0) begin
          src_idle = src_idle - 1;
          s_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          s_tdata  <= sample_q.pop_front();
          s_tvalid <= 1'b1;
          if (idle_en && $urandom_range(0, 11) == 0)
            src_idle = $urandom_range(1, 12);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each angle transaction, stalls in bursts, and once holds
  // off long enough for the pipeline to fill and drop s_tready.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_idle = 0;
      hold_left = 0;
      n_angles  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (angle_q.size() == 0) begin
          $error("angle_q6: unexpected result, actual %0d", m_tdata[14:0]);
          failed = 1'b1;
        end else if (m_tdata[14:0] != angle_q[0]) begin
          $error("angle_q6: expected %0d, actual %0d", angle_q[0], m_tdata[14:0]);
          failed = 1'b1;
        end
        if (angle_q.size() > 0) void'(angle_q.pop_front());
        n_angles = n_angles + 1;
        if (n_angles == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else if (sink_idle > 0) begin
        sink_idle = sink_idle - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 11) == 0)
          sink_idle = $urandom_range(1, 12);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL joystick_vector_angle");
      $finish;
    end
  end

  task automatic push_xy(int x, int y);
    sample_t s;
    s.raw_x = x[SAMPLE_W-1:0];
    s.raw_y = y[SAMPLE_W-1:0];
    sample_q.push_back(s);
  endtask

  // Wait until every sample is offered and every angle is back; checked at
  // the falling edge so all updates of the rising edge have settled.
  task automatic drain();
    while (sample_q.size() != 0 || s_tvalid || angle_q.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  // Writes both centers back to back; valid stays high between the two
  task automatic write_centers(int cx, int cy);
    cfg_valid <= 1'b1;
    cfg_index <= jva_pkg::REG_CENTER_X;
    cfg_data  <= cx[SAMPLE_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    ctr_x = cx;
    cfg_index <= jva_pkg::REG_CENTER_Y;
    cfg_data  <= cy[SAMPLE_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    ctr_y = cy;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int n, bit gaps);
    idle_en = gaps;
    repeat (n) sample_q.push_back(pick_sample());
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset centers: rest point, axes, corners, unit steps around
    // the center, left half plane and angles just below a full turn.
    push_xy(2048, 2048);
    push_xy(4095, 2048);
    push_xy(0,    2048);
    push_xy(2048, 0);
    push_xy(2048, 4095);
    push_xy(4095, 0);
    push_xy(0,    0);
    push_xy(0,    4095);
    push_xy(4095, 4095);
    push_xy(2049, 2048);
    push_xy(2047, 2048);
    push_xy(2048, 2047);
    push_xy(2048, 2049);
    push_xy(2047, 2047);
    push_xy(2047, 2049);
    push_xy(2049, 2049);
    push_xy(2049, 2047);
    push_xy(4095, 2049);
    push_xy(4095, 2047);
    push_xy(0,    2047);
    push_xy(0,    2049);
    push_xy(2049, 0);
    drain();

    // Center extremes; the long receiver stall lands in the first of these
    write_centers(0, 0);
    push_xy(0, 0);
    push_xy(4095, 4095);
    run_random(150, 1'b1);
    write_centers(4095, 4095);
    push_xy(4095, 4095);
    push_xy(0, 0);
    run_random(150, 1'b1);
    write_centers(0, 4095);
    run_random(120, 1'b0);
    write_centers(4095, 0);
    run_random(120, 1'b1);

    repeat (3) begin
      write_centers($urandom_range(0, SMAX), $urandom_range(0, SMAX));
      run_random(120, 1'b1);
    end

    // Final stretch at full rate on both sides
    write_centers($urandom_range(1024, 3071), $urandom_range(1024, 3071));
    run_random(130, 1'b0);

    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (failed)
      $display("FAIL joystick_vector_angle");
    else
      $display("PASS joystick_vector_angle");
    $finish;
  end

endmodule
